// ===== sv/wvcm_pkg.sv =====
// Shared types, constants and the arctangent table for the wind vane circular mean.
`default_nettype none
package wvcm_pkg;

    // Field widths
    localparam int ANG_W  = 12;  // angle counts, 4096 per turn
    localparam int SUM_W  = 24;  // signed cosine / sine accumulators
    localparam int Q15_W  = 16;  // Q1.15 cosine / sine values
    localparam int MIN_W  = 6;   // min_valid_samples and samples_used

    // Shared CORDIC datapath
    localparam int DW     = 40;  // x / y width, holds the sums times 4096 with gain
    localparam int ZW     = 22;  // angle accumulator, 2^20 units per turn
    localparam int ITERS  = 18;
    localparam int ITER_W = $clog2(ITERS);

    localparam logic signed [DW-1:0] CORDIC_GAIN = DW'(64'sd652032874);
    localparam logic signed [ZW-1:0] HALF_TURN   = ZW'(22'sd524288);

    // Configuration register indexes
    localparam logic [1:0] CFG_REVERSE = 2'd0;
    localparam logic [1:0] CFG_NORTH   = 2'd1;
    localparam logic [1:0] CFG_MIN     = 2'd2;

    typedef struct packed {
        logic              load;  // take the start vector
        logic              run;   // perform one micro-rotation
        logic              vect;  // vectoring (atan2) rather than rotation
        logic [ITER_W-1:0] iter;  // step number, also the shift amount
    } t_cordic_ctl;

    // Arctangent of 2^-i in units of 2^20 per turn.
    function automatic logic signed [ZW-1:0] atan_units(input logic [ITER_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 22'sd131072;
            5'd1:    v = 22'sd77376;
            5'd2:    v = 22'sd40884;
            5'd3:    v = 22'sd20753;
            5'd4:    v = 22'sd10417;
            5'd5:    v = 22'sd5213;
            5'd6:    v = 22'sd2607;
            5'd7:    v = 22'sd1304;
            5'd8:    v = 22'sd652;
            5'd9:    v = 22'sd326;
            5'd10:   v = 22'sd163;
            5'd11:   v = 22'sd81;
            5'd12:   v = 22'sd41;
            5'd13:   v = 22'sd20;
            5'd14:   v = 22'sd10;
            5'd15:   v = 22'sd5;
            5'd16:   v = 22'sd3;
            5'd17:   v = 22'sd1;
            default: v = 22'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/wind_vane_circular_mean.sv =====
// Top level of the wind vane circular mean: sequencer, accumulators and ports.
//
// Channel  | Direction | Handshake                         | Payload
// ---------+-----------+-----------------------------------+---------------------------------
// s_axis   | in        | i_s_axis_tvalid / o_s_axis_tready | tdata raw_angle, tuser sample_ok,
//          |           |                                   | tlast last_sample
// m_axis   | out       | o_m_axis_tvalid / i_m_axis_tready | tdata direction, samples_used,
//          |           |                                   | tuser status
// cfg      | in        | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data
//
// A valid sample takes 18 rotation steps on the shared CORDIC; the accumulate state then
// adds its cosine and sine. A skipped sample not ending the burst leaves the sequencer
// idle. The last item of a burst adds a check state, then, unless too few samples were
// used or the sums are zero, 18 vectoring steps for the atan2 and a rounding state, and
// a state that hands the result to the output register. The output register lets the
// next burst start while a result waits; a further result waits in the sequencer until
// that register is free. Reset is synchronous and active low; it clears the sums, the
// count and the configuration registers (minimum sample count returns to 15).
`default_nettype none
module wind_vane_circular_mean
    import wvcm_pkg::*;
#(
    parameter int MAX_SAMPLES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input samples
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // [11:0] raw_angle, [15:12] zero
    input  wire         i_s_axis_tuser,   // [0] sample_ok
    input  wire         i_s_axis_tlast,   // last_sample
    // Results
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [11:0] direction, [17:12] samples_used, [23:18] zero
    output logic        o_m_axis_tuser,   // [0] status
    // Configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [11:0] i_cfg_data
);

    // The count must hold MAX_SAMPLES itself.
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CW > MIN_W) ? CW : MIN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROT   = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_VEC   = 3'd4;
    localparam logic [2:0] S_DIRN  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Configuration
    logic              r_reverse;
    logic [ANG_W-1:0]  r_north;
    logic [MIN_W-1:0]  r_min_valid;

    // Sequencer and burst state
    logic [2:0]        r_state;
    logic [ITER_W-1:0] r_iter;
    logic [1:0]        r_quad;
    logic              r_last;
    logic signed [SUM_W-1:0] r_cos_sum, r_sin_sum;
    logic [CW-1:0]     r_count;

    // Pending result and the output register
    logic [ANG_W-1:0]  r_res_dir;
    logic              r_res_status;
    logic              r_out_valid;
    logic [ANG_W-1:0]  r_out_dir;
    logic              r_out_status;
    logic [MIN_W-1:0]  r_out_count;

    logic              w_accept;
    logic              w_take;
    logic              w_too_few;
    logic              w_zero_sums;
    logic              w_out_free;
    logic [ANG_W-1:0]  w_mirror, w_angle;
    logic [CMP_W-1:0]  w_count_ext, w_min_ext;
    logic signed [DW-1:0] w_cx, w_sy, w_vx, w_vy;
    logic signed [DW-1:0] w_x0, w_y0;
    logic signed [ZW-1:0] w_z0, w_vz, w_zr;
    logic signed [DW-1:0] w_cx_out, w_cy_out;
    logic signed [ZW-1:0] w_cz_out;
    logic signed [Q15_W-1:0] w_cq, w_sq, w_c, w_s;
    t_cordic_ctl       w_ctl;

    // Round half up to Q1.15 and clamp to the symmetric range.
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] t;
        logic signed [DW-1:0] r;
        logic signed [Q15_W-1:0] q;
        t = v + DW'(40'sd16384);
        r = t >>> 15;
        if (r > DW'(40'sd32767)) begin
            q = 16'sd32767;
        end else if (r < -DW'(40'sd32767)) begin
            q = -16'sd32767;
        end else begin
            q = r[Q15_W-1:0];
        end
        return q;
    endfunction

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    // A sample enters the sums only if its read succeeded and the burst is not full.
    assign w_take          = i_s_axis_tuser && (r_count < CW'(MAX_SAMPLES));
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // Mirror, then subtract the north offset; both wrap modulo one turn.
    assign w_mirror = r_reverse ? (ANG_W'(0) - i_s_axis_tdata[ANG_W-1:0])
                                : i_s_axis_tdata[ANG_W-1:0];
    assign w_angle  = w_mirror - r_north;

    assign w_count_ext = CMP_W'(r_count);
    assign w_min_ext   = CMP_W'(r_min_valid);
    assign w_too_few   = w_count_ext < w_min_ext;
    assign w_zero_sums = (r_cos_sum == '0) && (r_sin_sum == '0);

    // Vectoring start: sums scaled by 4096, left half plane turned by half a turn.
    assign w_cx = {{(DW-SUM_W-ANG_W){r_cos_sum[SUM_W-1]}}, r_cos_sum, {ANG_W{1'b0}}};
    assign w_sy = {{(DW-SUM_W-ANG_W){r_sin_sum[SUM_W-1]}}, r_sin_sum, {ANG_W{1'b0}}};
    assign w_vx = r_cos_sum[SUM_W-1] ? -w_cx : w_cx;
    assign w_vy = r_cos_sum[SUM_W-1] ? -w_sy : w_sy;
    assign w_vz = r_cos_sum[SUM_W-1] ? HALF_TURN : '0;

    // Rotation start: gain-compensated unit vector, angle within the quadrant.
    assign w_x0 = (r_state == S_IDLE) ? CORDIC_GAIN : w_vx;
    assign w_y0 = (r_state == S_IDLE) ? '0 : w_vy;
    assign w_z0 = (r_state == S_IDLE) ? ZW'({w_angle[9:0], 8'b0}) : w_vz;

    always_comb begin
        w_ctl.load = (w_accept && w_take)
                     || ((r_state == S_CHECK) && !w_too_few && !w_zero_sums);
        w_ctl.run  = (r_state == S_ROT) || (r_state == S_VEC);
        w_ctl.vect = (r_state == S_VEC);
        w_ctl.iter = r_iter;
    end

    wvcm_cordic u_cordic (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_x0  (w_x0),
        .i_y0  (w_y0),
        .i_z0  (w_z0),
        .o_x   (w_cx_out),
        .o_y   (w_cy_out),
        .o_z   (w_cz_out)
    );

    // Quadrant mapping of the first-quadrant cosine and sine.
    assign w_cq = to_q15(w_cx_out);
    assign w_sq = to_q15(w_cy_out);
    always_comb begin
        case (r_quad)
            2'd0:    begin w_c = w_cq;  w_s = w_sq;  end
            2'd1:    begin w_c = -w_sq; w_s = w_cq;  end
            2'd2:    begin w_c = -w_cq; w_s = -w_sq; end
            default: begin w_c = w_sq;  w_s = -w_cq; end
        endcase
    end

    // Round the 2^20-per-turn angle to 4096 counts; the low twelve bits wrap it.
    assign w_zr = w_cz_out + ZW'(22'sd128);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_cos_sum   <= '0;
            r_sin_sum   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_reverse   <= 1'b0;
            r_north     <= '0;
            r_min_valid <= MIN_W'(15);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_REVERSE: r_reverse   <= i_cfg_data[0];
                    CFG_NORTH:   r_north     <= i_cfg_data[ANG_W-1:0];
                    CFG_MIN:     r_min_valid <= i_cfg_data[MIN_W-1:0];
                    default:     ;
                endcase
            end

            // A new result fills the output register as the old one leaves.
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_iter <= '0;
                        if (w_take) begin
                            r_state <= S_ROT;
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_ROT: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_W'(ITERS - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_cos_sum <= r_cos_sum + SUM_W'(w_c);
                    r_sin_sum <= r_sin_sum + SUM_W'(w_s);
                    r_count   <= r_count + 1'b1;
                    r_iter    <= '0;
                    r_state   <= r_last ? S_CHECK : S_IDLE;
                end
                S_CHECK: begin
                    r_iter  <= '0;
                    r_state <= (w_too_few || w_zero_sums) ? S_OUT : S_VEC;
                end
                S_VEC: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_W'(ITERS - 1)) begin
                        r_state <= S_DIRN;
                    end
                end
                S_DIRN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_cos_sum   <= '0;
                        r_sin_sum   <= '0;
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_quad <= w_angle[ANG_W-1:ANG_W-2];
            r_last <= i_s_axis_tlast;
        end
        if (r_state == S_CHECK) begin
            r_res_dir    <= '0;
            r_res_status <= w_too_few;
        end
        if (r_state == S_DIRN) begin
            r_res_dir    <= w_zr[19:8];
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_dir    <= r_res_dir;
            r_out_status <= r_res_status;
            r_out_count  <= w_count_ext[MIN_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_count, r_out_dir};
    assign o_m_axis_tuser  = r_out_status;

endmodule
`default_nettype wire

// ===== sv/wvcm_cordic.sv =====
// Shared CORDIC unit: one micro-rotation per cycle, rotation or vectoring mode.
`default_nettype none
module wvcm_cordic
    import wvcm_pkg::*;
(
    input  wire                        i_clk,
    input  wire t_cordic_ctl           i_ctl,
    input  wire logic signed [DW-1:0]  i_x0,
    input  wire logic signed [DW-1:0]  i_y0,
    input  wire logic signed [ZW-1:0]  i_z0,
    output logic signed [DW-1:0]       o_x,
    output logic signed [DW-1:0]       o_y,
    output logic signed [ZW-1:0]       o_z
);

    logic signed [DW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [DW-1:0] w_dx, w_dy;
    logic signed [ZW-1:0] w_dz;
    logic                 w_ccw;

    assign w_dx = r_y >>> i_ctl.iter;
    assign w_dy = r_x >>> i_ctl.iter;
    assign w_dz = atan_units(i_ctl.iter);
    // Rotation drives z towards zero; vectoring drives y towards zero.
    assign w_ccw = i_ctl.vect ? r_y[DW-1] : ~r_z[ZW-1];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x0;
            r_y <= i_y0;
            r_z <= i_z0;
        end else if (i_ctl.run) begin
            if (w_ccw) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_dz;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_dz;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the wind vane circular mean block.
`timescale 1ns / 1ps

module tb;
    import wvcm_pkg::*;

    // The block is built with its default saturation count.
    localparam int MAX_SAMPLES   = 32;
    // Cycles left to the block after the last result, well beyond a full atan2 pass.
    localparam int SETTLE_CYCLES = 64;
    // A generous bound on the whole run, many times the slowest legal run.
    localparam int CYCLE_LIMIT   = 600000;
    // An index outside the register map; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ANG_W-1:0] direction;
        logic             too_few;
        logic [MIN_W-1:0] used;
    } t_vane_result;

    // Block inputs, all known from time zero.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [15:0] i_s_axis_tdata  = '0;    // [11:0] raw_angle, [15:12] zero
    logic        i_s_axis_tuser  = 1'b0;  // [0] sample_ok
    logic        i_s_axis_tlast  = 1'b0;  // last_sample
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = '0;
    logic [11:0] i_cfg_data      = '0;

    // Block outputs.
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [23:0] o_m_axis_tdata;          // [11:0] direction, [17:12] samples_used
    wire         o_m_axis_tuser;          // [0] status
    wire         o_cfg_ready;

    wind_vane_circular_mean #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow copy of the configuration and of the burst accumulators.
    logic             mirror_en;
    logic [ANG_W-1:0] north_cnt;
    logic [MIN_W-1:0] min_needed;
    int               cos_acc;
    int               sin_acc;
    int               used_cnt;

    // Mean directions still owed by the block, oldest first.
    t_vane_result expected_q[$];

    // Idle rates in percent for the two sides of the stream.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Bookkeeping for the closing summary and the stop condition.
    int errors          = 0;
    int cycle_count     = 0;
    int effective_items = 0;
    int bursts_done     = 0;
    int low_count_bursts = 0;
    int full_bursts     = 0;
    int results_seen    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Arctangent of 2^-i in units of 2^20 per turn.
    function automatic longint arctan_step(input int i);
        case (i)
            0:       return 131072;
            1:       return 77376;
            2:       return 40884;
            3:       return 20753;
            4:       return 10417;
            5:       return 5213;
            6:       return 2607;
            7:       return 1304;
            8:       return 652;
            9:       return 326;
            10:      return 163;
            11:      return 81;
            12:      return 41;
            13:      return 20;
            14:      return 10;
            15:      return 5;
            16:      return 3;
            default: return 1;
        endcase
    endfunction

    // Round half up from Q2.30 to Q1.15 and clamp to the symmetric range.
    function automatic int q15_round(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767)  r = 32767;
        if (r < -32767) r = -32767;
        return int'(r);
    endfunction

    // Cosine and sine of an angle: rotate within the quadrant, then fold the quadrant in.
    function automatic void unit_vector(input logic [ANG_W-1:0] ang, output int c, output int s);
        longint x, y, z, dx, dy;
        int     cq, sq, i;
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = longint'(ang[9:0]) * 256;
        for (i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        cq = q15_round(x);
        sq = q15_round(y);
        case (ang[11:10])
            2'd0:    begin c = cq;  s = sq;  end
            2'd1:    begin c = -sq; s = cq;  end
            2'd2:    begin c = -cq; s = -sq; end
            default: begin c = sq;  s = -cq; end
        endcase
    endfunction

    // Direction of the summed vector; a vector in the left half plane is first
    // turned by half a turn so that vectoring converges.
    function automatic logic [ANG_W-1:0] mean_heading(input int cs, input int sn);
        longint x, y, z, dx, dy;
        int     i;
        if (cs == 0 && sn == 0) return '0;
        x = longint'(cs) * 4096;
        y = longint'(sn) * 4096;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd524288;
        end
        for (i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_step(i);
            end else begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
        end
        z = (z + 128) >>> 8;
        return z[ANG_W-1:0];
    endfunction

    // Follow one accepted sample through the shadow state; a burst end owes a result.
    task automatic track_sample(input logic [ANG_W-1:0] raw, input logic ok, input logic last);
        logic [ANG_W-1:0] a;
        int               c, s;
        t_vane_result     r;
        if (ok && used_cnt < MAX_SAMPLES) begin
            a = mirror_en ? (12'd0 - raw) : raw;
            a = a - north_cnt;
            unit_vector(a, c, s);
            cos_acc += c;
            sin_acc += s;
            used_cnt++;
        end
        if ((ok && used_cnt <= MAX_SAMPLES) || last) effective_items++;
        if (last) begin
            r.too_few   = (used_cnt < min_needed);
            r.direction = r.too_few ? '0 : mean_heading(cos_acc, sin_acc);
            r.used      = MIN_W'(used_cnt);
            expected_q.push_back(r);
            bursts_done++;
            if (r.too_few) low_count_bursts++;
            if (used_cnt == MAX_SAMPLES) full_bursts++;
            cos_acc  = 0;
            sin_acc  = 0;
            used_cnt = 0;
        end
    endtask

    // Offer one sample after a random gap; returns at the edge that accepts it,
    // leaving tvalid high so that a following item can go out back to back.
    task automatic send_sample(input logic [ANG_W-1:0] ang, input logic ok, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, ang};
        i_s_axis_tuser  <= ok;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_sample(ang, ok, last);
    endtask

    // One register write; the valid stays high for a following write.
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REVERSE: mirror_en  = val[0];
            CFG_NORTH:   north_cnt  = val;
            CFG_MIN:     min_needed = val[MIN_W-1:0];
            default:     ;
        endcase
    endtask

    // Full register set, preceded by a stray write to the unused index.
    task automatic configure(input logic rev, input logic [11:0] north, input int minv);
        write_reg(CFG_UNUSED, 12'($urandom));
        write_reg(CFG_REVERSE, {11'd0, rev});
        write_reg(CFG_NORTH, north);
        write_reg(CFG_MIN, 12'(minv));
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering samples, wait for every owed result, then let the block settle.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reset values: minimum of 15, so a short burst with a skipped sample is too few.
    task automatic test_reset_defaults();
        send_sample(12'd100, 1'b1, 1'b0);
        send_sample(12'hfff, 1'b0, 1'b0);
        send_sample(12'd0, 1'b1, 1'b1);
    endtask

    // A burst of only skipped samples is still a valid result when no minimum applies.
    task automatic test_empty_burst();
        wait_idle();
        configure(1'b0, 12'd0, 0);
        send_sample(12'hfff, 1'b0, 1'b1);
    endtask

    // Opposite vectors cancel exactly and must report north.
    task automatic test_cancelling_vectors();
        send_sample(12'd0, 1'b1, 1'b0);
        send_sample(12'd2048, 1'b1, 1'b1);
    endtask

    // Mirroring at the angle extremes, then the largest offset with a minimum of 32, then without mirroring.
    task automatic test_mirror_and_offset_extremes();
        wait_idle();
        configure(1'b1, 12'd0, 1);
        send_sample(12'd0, 1'b1, 1'b0);
        send_sample(12'hfff, 1'b1, 1'b0);
        send_sample(12'd2048, 1'b1, 1'b1);
        send_sample(12'd1024, 1'b1, 1'b1);
        wait_idle();
        configure(1'b1, 12'hfff, 32);
        send_sample(12'd0, 1'b1, 1'b0);
        send_sample(12'hfff, 1'b1, 1'b1);
        wait_idle();
        configure(1'b0, 12'hfff, 1);
        send_sample(12'hfff, 1'b1, 1'b1);
        send_sample(12'd1, 1'b1, 1'b0);
        send_sample(12'd3072, 1'b0, 1'b1);
    endtask

    // Random bursts under one configuration and one idling pattern. Most bursts
    // are well formed with mostly good reads, some run past saturation, and a
    // few are short and noisy.
    task automatic test_random_bursts(input logic rev, input logic [11:0] north, input int minv,
                                      input int send_pct, input int recv_pct, input int n_items);
        int               start_items, kind, len, ok_pct, spread, k;
        logic [ANG_W-1:0] centre, ang;
        wait_idle();
        configure(rev, north, minv);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_items   = effective_items;
        while (effective_items - start_items < n_items) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                len = $urandom_range(1, 20); ok_pct = 92;
            end else if (kind < 85) begin
                len = $urandom_range(30, 40); ok_pct = 97;
            end else begin
                len = $urandom_range(1, 6); ok_pct = 30;
            end
            centre = 12'($urandom);
            case ($urandom_range(2))
                0:       spread = 16;
                1:       spread = 256;
                default: spread = 1024;
            endcase
            for (k = 0; k < len; k++) begin
                if ($urandom_range(99) < 60)
                    ang = centre + 12'($urandom_range(2 * spread)) - 12'(spread);
                else
                    ang = 12'($urandom);
                send_sample(ang, $urandom_range(99) < ok_pct, k == len - 1);
            end
        end
    endtask

    // Result checker; also drives the receiver's stalls, one assignment per edge.
    always @(posedge i_clk) begin : result_check
        t_vane_result want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result dir=%0d status=%0b used=%0d", $time,
                         o_m_axis_tdata[11:0], o_m_axis_tuser, o_m_axis_tdata[17:12]);
            end else begin
                want = expected_q.pop_front();
                if (o_m_axis_tdata[11:0] !== want.direction || o_m_axis_tuser !== want.too_few ||
                    o_m_axis_tdata[17:12] !== want.used) begin
                    errors++;
                    $display("%0t: mismatch expected dir=%0d status=%0b used=%0d, got dir=%0d status=%0b used=%0d",
                             $time, want.direction, want.too_few, want.used,
                             o_m_axis_tdata[11:0], o_m_axis_tuser, o_m_axis_tdata[17:12]);
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles with %0d results owed", $time, CYCLE_LIMIT,
                     expected_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        // Shadow state matches the block's reset values.
        mirror_en  = 1'b0;
        north_cnt  = '0;
        min_needed = MIN_W'(15);
        cos_acc    = 0;
        sin_acc    = 0;
        used_cnt   = 0;

        // The directed part already runs with the first idling pattern.
        send_idle_pct = 29;
        recv_idle_pct = 86;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_empty_burst();
        test_cancelling_vectors();
        test_mirror_and_offset_extremes();

        test_random_bursts(1'b0, 12'd0, 15, 29, 86, 100);
        test_random_bursts(1'b1, 12'hfff, 32, 29, 86, 100);
        test_random_bursts(1'b0, 12'($urandom), 0, 86, 29, 100);
        test_random_bursts(1'b1, 12'($urandom), $urandom_range(32), 86, 29, 100);
        test_random_bursts(1'($urandom), 12'($urandom), $urandom_range(32), 0, 0, 100);
        test_random_bursts(1'($urandom), 12'($urandom), 1, 0, 0, 100);

        wait_idle();
        $display("Covered %0d counted samples in %0d bursts: %0d too short, %0d saturated.",
                 effective_items, bursts_done, low_count_bursts, full_bursts);
        $display("Checked %0d results over six configurations and three idling patterns.",
                 results_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
